/* src/ordered_list_insert_delete_find_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the ordered list core
// Each macro expands to one labeled concurrent assertion on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_FIND_CORE_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_FIND_CORE_ASSERT_SVH

// Check that a condition holds at every clock edge
`define OLIDF_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a trigger implies a consequence in the same cycle
`define OLIDF_IMPLIES(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

/* src/olidf_pkg.sv */
// ----------------------------------------------------------------------------
// olidf_pkg
// Shared constants for the ordered list core: widths, request and status codes.
// ----------------------------------------------------------------------------
package olidf_pkg;

    // Default number of list entries
    localparam int CAPACITY_DEF = 16;

    // Word and code widths
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    // Request codes
    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

/* src/olidf_ram.sv */
// ----------------------------------------------------------------------------
// olidf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module olidf_ram
    import olidf_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word and register one read each cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/ordered_list_insert_delete_find_core.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_find_core
// Fixed-capacity positional list of signed words with find, insert, delete.
//
//   channel   ports                               handshake
//   request   operation, value, position          start, taken when !busy
//   result    status, found_index, length         done, one-cycle strobe
//
// Entries live in one RAM; a sequencer walks it one entry per cycle through
// a shared index stepper and one word comparator.
// Refused requests, appends and the unused code finish without a walk.
// done is registered from the last step; busy drops as done rises.
// Reset clears the length, state and result registers; the RAM is never cleared.
// The receiver cannot stall, so results never back up.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_find_core
    import olidf_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          operation,
    input  logic signed [DATA_W-1:0] value,
    input  logic [CNT_W-1:0]         position,
    output logic                     done,
    output logic [ST_W-1:0]          status,
    output logic [IDX_W-1:0]         found_index,
    output logic [CNT_W-1:0]         length
);

`include "ordered_list_insert_delete_find_core_assert.svh"

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_UP,
        S_PUT,
        S_DOWN
    } state_t;

    state_t             state_reg, state_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   src_reg, src_next;
    logic [IDX_W-1:0]   dst_reg, dst_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               done_reg, done_next;
    logic [ST_W-1:0]    status_reg, status_next;
    logic [IDX_W-1:0]   found_reg, found_next;
    logic [CNT_W-1:0]   length_reg, length_next;

    // Shared index stepper and word comparator
    logic [CNT_W-1:0]   step_in;
    logic               step_dec;
    logic [CNT_W-1:0]   step_out;
    logic               word_match;

    // RAM port signals
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;

    olidf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Step an index up or down by one
    assign step_out   = step_dec ? (step_in - CNT_W'(1)) : (step_in + CNT_W'(1));
    assign word_match = (mem_rdata == value_reg);

    // Sequence one request
    always_comb
    begin
        state_next  = state_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        length_next = length_reg;
        step_in     = {CNT_W{1'b0}};
        step_dec    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = dst_reg;
        mem_wdata   = mem_rdata;
        mem_raddr   = src_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next  = value;
                    pos_next    = position[IDX_W-1:0];
                    status_next = ST_DONE;
                    found_next  = {IDX_W{1'b0}};
                    length_next = count_reg;
                    unique case (operation)
                        OP_FIND:
                        begin
                            if (count_reg == {CNT_W{1'b0}})
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                mem_raddr  = {IDX_W{1'b0}};
                                src_next   = {IDX_W{1'b0}};
                                state_next = S_FIND;
                            end
                        end
                        OP_INSERT:
                        begin
                            step_in  = count_reg;
                            step_dec = 1'b1;
                            priority if (count_reg == CAP_C)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else if (position > count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_RANGE;
                            end
                            else if (position == count_reg)
                            begin
                                // Append at the end: no entries to move
                                mem_we      = 1'b1;
                                mem_waddr   = position[IDX_W-1:0];
                                mem_wdata   = value;
                                count_next  = count_reg + CNT_W'(1);
                                length_next = count_reg + CNT_W'(1);
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                // Move entries up, starting from the last one
                                mem_raddr  = step_out[IDX_W-1:0];
                                src_next   = step_out[IDX_W-1:0];
                                dst_next   = count_reg[IDX_W-1:0];
                                state_next = S_UP;
                            end
                        end
                        OP_DELETE:
                        begin
                            step_in = position;
                            if (position >= count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_RANGE;
                            end
                            else if (step_out == count_reg)
                            begin
                                // Drop the last entry: no entries to move
                                count_next  = count_reg - CNT_W'(1);
                                length_next = count_reg - CNT_W'(1);
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                // Move entries down, starting after the hole
                                mem_raddr  = step_out[IDX_W-1:0];
                                src_next   = step_out[IDX_W-1:0];
                                dst_next   = position[IDX_W-1:0];
                                state_next = S_DOWN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_FIND:
            begin
                step_in = CNT_W'(src_reg);
                priority if (word_match)
                begin
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    found_next  = src_reg;
                    state_next  = S_IDLE;
                end
                else if (step_out == count_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOTFOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_raddr = step_out[IDX_W-1:0];
                    src_next  = step_out[IDX_W-1:0];
                end
            end

            S_UP:
            begin
                // Copy the word just read one place up
                mem_we   = 1'b1;
                step_in  = CNT_W'(src_reg);
                step_dec = 1'b1;
                if (src_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    mem_raddr = step_out[IDX_W-1:0];
                    src_next  = step_out[IDX_W-1:0];
                    dst_next  = src_reg;
                end
            end

            S_PUT:
            begin
                // Store the new word in the opened place
                mem_we      = 1'b1;
                mem_waddr   = pos_reg;
                mem_wdata   = value_reg;
                count_next  = count_reg + CNT_W'(1);
                length_next = count_reg + CNT_W'(1);
                done_next   = 1'b1;
                status_next = ST_DONE;
                state_next  = S_IDLE;
            end

            S_DOWN:
            begin
                // Copy the word just read one place down
                mem_we  = 1'b1;
                step_in = CNT_W'(src_reg);
                if (step_out == count_reg)
                begin
                    count_next  = count_reg - CNT_W'(1);
                    length_next = count_reg - CNT_W'(1);
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_raddr = step_out[IDX_W-1:0];
                    src_next  = step_out[IDX_W-1:0];
                    dst_next  = src_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, length and the result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= {CNT_W{1'b0}};
            done_reg   <= 1'b0;
            value_reg  <= {DATA_W{1'b0}};
            pos_reg    <= {IDX_W{1'b0}};
            src_reg    <= {IDX_W{1'b0}};
            dst_reg    <= {IDX_W{1'b0}};
            status_reg <= ST_DONE;
            found_reg  <= {IDX_W{1'b0}};
            length_reg <= {CNT_W{1'b0}};
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            value_reg  <= value_next;
            pos_reg    <= pos_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            status_reg <= status_next;
            found_reg  <= found_next;
            length_reg <= length_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign length      = length_reg;

    // Length never passes the capacity
    `OLIDF_ALWAYS(a_count_cap, count_reg <= CAP_C, "list length above capacity")
    // Leaving a multi-cycle request always posts its result
    `OLIDF_IMPLIES(a_fall_done, $fell(busy), done, "request ended without a result")
    // A search never writes the list
    `OLIDF_IMPLIES(a_find_ro, state_reg == S_FIND, !mem_we, "write during find")
    // Upward move never passes the insert position
    `OLIDF_IMPLIES(a_up_pos, state_reg == S_UP, src_reg >= pos_reg, "shift passed position")
    // Downward move reads only live entries
    `OLIDF_IMPLIES(a_down_live, state_reg == S_DOWN, CNT_W'(src_reg) < count_reg, "bad read")

endmodule

/* tb/tb_ordered_list_insert_delete_find_core.sv */
// ----------------------------------------------------------------------------
// Ordered list core testbench
// Sends find, insert and delete words through the start/busy handshake and
// checks every done strobe against a local model of the list contents.
// Directed tests cover the empty and full list, refused positions and the
// unused request code; random bursts then grow, drain and search the list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ordered_list_insert_delete_find_core;

    import olidf_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Request code that the block treats as a no-op
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Burst flavors for the random part
    typedef enum int {GROW, DRAIN, MIXED} burst_kind_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] found_index;
        logic [CNT_W-1:0] length;
    } list_reply_t;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     start     = 1'b0;
    logic                     busy;
    logic [OP_W-1:0]          operation = '0;
    logic signed [DATA_W-1:0] value     = '0;
    logic [CNT_W-1:0]         position  = '0;
    logic                     done;
    logic [ST_W-1:0]          status;
    logic [IDX_W-1:0]         found_index;
    logic [CNT_W-1:0]         length;

    // Local copy of the list
    logic [DATA_W-1:0] list_words [CAPACITY];
    int                list_len;

    list_reply_t pending_replies[$];
    int          error_count;
    bit          gaps_on;

    ordered_list_insert_delete_find_core #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .value       (value),
        .position    (position),
        .done        (done),
        .status      (status),
        .found_index (found_index),
        .length      (length)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // End the run if it hangs
    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Apply one request to the local list and return the reply it yields
    function automatic list_reply_t apply_request(input logic [OP_W-1:0] op,
                                                  input logic [DATA_W-1:0] val,
                                                  input logic [CNT_W-1:0] pos);
        list_reply_t r;
        r.status      = ST_DONE;
        r.found_index = '0;
        case (op)
            OP_FIND:
            begin
                r.status = ST_NOTFOUND;
                for (int i = list_len - 1; i >= 0; i--)
                begin
                    if (list_words[i] == val)
                    begin
                        r.status      = ST_DONE;
                        r.found_index = IDX_W'(i);
                    end
                end
            end
            OP_INSERT:
            begin
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else if (int'(pos) > list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (int i = list_len; i > int'(pos); i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = val;
                    list_len++;
                end
            end
            OP_DELETE:
            begin
                if (int'(pos) >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (int i = int'(pos); i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            default: ;
        endcase
        r.length = CNT_W'(list_len);
        return r;
    endfunction

    // Drive one word and hold it until the block takes it; start stays high
    task automatic send_word(input logic [OP_W-1:0] op,
                             input logic [DATA_W-1:0] val,
                             input logic [CNT_W-1:0] pos);
        start     <= 1'b1;
        operation <= op;
        value     <= val;
        position  <= pos;
        do
            @(posedge clk);
        while (busy);
        pending_replies.push_back(apply_request(op, val, pos));
    endtask

    // Drop start for a random number of cycles, mostly short
    task automatic idle_gap();
        int n;
        int pick;
        pick = $urandom_range(0, 99);
        if (!gaps_on || pick < 55)
            n = 0;
        else if (pick < 90)
            n = $urandom_range(1, 4);
        else
            n = $urandom_range(8, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Check each result against the oldest expected reply
    always @(posedge clk)
    begin
        list_reply_t exp_r;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
                report_mismatch($sformatf("unexpected result st=%0d idx=%0d len=%0d",
                                          status, found_index, length));
            else
            begin
                exp_r = pending_replies.pop_front();
                if (status !== exp_r.status)
                    report_mismatch($sformatf("status got %0d exp %0d",
                                              status, exp_r.status));
                if (found_index !== exp_r.found_index)
                    report_mismatch($sformatf("found_index got %0d exp %0d",
                                              found_index, exp_r.found_index));
                if (length !== exp_r.length)
                    report_mismatch($sformatf("length got %0d exp %0d",
                                              length, exp_r.length));
            end
        end
    end

    // Find, delete and a beyond-length insert on an empty list
    task automatic test_empty_list();
        send_word(OP_FIND, 32'h0000_0000, 5'd0);
        send_word(OP_DELETE, 32'h1234_5678, 5'd0);
        send_word(OP_INSERT, 32'h1234_5678, 5'd1);
    endtask

    // Fill at front, back and middle with extreme words, then overflow
    task automatic test_fill_and_overflow();
        logic [DATA_W-1:0] words [4];
        words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
        for (int i = 0; i < CAPACITY; i++)
        begin
            case (i % 3)
                0: send_word(OP_INSERT, words[i % 4], CNT_W'(list_len));
                1: send_word(OP_INSERT, words[i % 4], '0);
                default: send_word(OP_INSERT, words[i % 4], CNT_W'(list_len / 2));
            endcase
            idle_gap();
        end
        // Fullness wins over a bad position
        send_word(OP_INSERT, 32'h5555_5555, 5'd0);
        send_word(OP_INSERT, 32'hAAAA_AAAA, 5'd31);
    endtask

    // Find duplicates and a missing word, delete at the edges
    task automatic test_find_and_delete();
        send_word(OP_FIND, 32'h8000_0000, 5'd31);
        send_word(OP_FIND, 32'h0BAD_F00D, 5'd0);
        send_word(OP_DELETE, '0, CNT_W'(CAPACITY));
        send_word(OP_DELETE, '0, CNT_W'(CAPACITY - 1));
        send_word(OP_DELETE, '0, 5'd0);
    endtask

    task automatic test_unused_operation();
        send_word(OP_UNUSED, 32'hFFFF_FFFF, 5'd31);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $urandom();
        else if (pick < 80)
            return DATA_W'($signed($urandom_range(0, 15)) - 8);
        else if (pick < 90)
            return 32'h7FFF_FFFF - $urandom_range(0, 1);
        else
            return 32'h8000_0000 + $urandom_range(0, 1);
    endfunction

    // Random bursts that grow, drain or churn the list
    task automatic test_random(input int n_words);
        burst_kind_t       kind;
        int                sent;
        int                pick;
        int                ins_w;
        int                del_w;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] val;
        logic [CNT_W-1:0]  pos;
        sent = 0;
        while (sent < n_words)
        begin
            kind    = burst_kind_t'($urandom_range(0, 2));
            gaps_on = ($urandom_range(0, 3) != 0);
            ins_w   = (kind == GROW) ? 60 : (kind == DRAIN) ? 15 : 35;
            del_w   = (kind == GROW) ? 15 : (kind == DRAIN) ? 60 : 35;
            repeat ($urandom_range(20, 60))
            begin
                pick = $urandom_range(0, 99);
                val  = pick_word();
                pos  = CNT_W'($urandom_range(0, 31));
                if (pick < 2)
                    op = OP_UNUSED;
                else if (pick < 2 + ins_w)
                begin
                    op = OP_INSERT;
                    if ($urandom_range(0, 99) < 88)
                        pos = CNT_W'($urandom_range(0, list_len));
                end
                else if (pick < 2 + ins_w + del_w)
                begin
                    op = OP_DELETE;
                    if (list_len > 0 && $urandom_range(0, 99) < 88)
                        pos = CNT_W'($urandom_range(0, list_len - 1));
                end
                else
                begin
                    op = OP_FIND;
                    // Look up a stored word most of the time
                    if (list_len > 0 && $urandom_range(0, 99) < 70)
                        val = list_words[$urandom_range(0, list_len - 1)];
                end
                send_word(op, val, pos);
                idle_gap();
                sent++;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        error_count = 0;
        list_len    = 0;
        gaps_on     = 1'b1;
        foreach (list_words[i])
            list_words[i] = '0;

        // Hold reset, then release on an edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_fill_and_overflow();
        test_find_and_delete();
        test_unused_operation();
        test_random(1925);

        // Drain outstanding results
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/olidf_pkg.sv
src/olidf_ram.sv
src/ordered_list_insert_delete_find_core.sv
tb/tb_ordered_list_insert_delete_find_core.sv
